/* rtl/tspm_pkg.sv */
package tspm_pkg;

  localparam int unsigned XY_W       = 12;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [XY_W-1:0]      FULL_SCALE  = 12'hFFF;
  localparam logic [PROD_W-1:0]    ROUND_ADD   = 32'd2047;
  localparam logic [DIV_CNT_W-1:0] PRESS_STEPS = 6'd32;

  // Configuration register indexes.
  localparam logic [1:0] REG_PLATE_OHMS   = 2'd0;
  localparam logic [1:0] REG_LINE_PRESENT = 2'd1;
  localparam logic [1:0] REG_PRESS_LIMIT  = 2'd2;

  // Request to the iterative divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

endpackage

/* rtl/tspm_cell.sv */
module tspm_cell
  import tspm_pkg::*;
(
  input  logic            clk,
  input  logic            shift,
  input  logic [XY_W-1:0] in_x,
  input  logic [XY_W-1:0] in_y,
  output logic [XY_W-1:0] x,
  output logic [XY_W-1:0] y
);

  // One stored sample; on a shift it takes its neighbor's sample.
  always_ff @(posedge clk) begin
    if (shift) begin
      x <= in_x;
      y <= in_y;
    end
  end

endmodule

/* rtl/tspm_div.sv */
module tspm_div
  import tspm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [PROD_W-1:0] dividend,
  input  logic [XY_W-1:0]   divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [XY_W-1:0]      rem;
  logic [XY_W-1:0]      dsr;
  logic [XY_W:0]        trial;
  logic                 fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quotient while quotient bits enter at the bottom.
  assign trial = {rem, quotient[PROD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[PROD_W-2:0], fits};
      if (fits) begin
        rem <= XY_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[XY_W-1:0];
      end
    end
  end

endmodule

/* rtl/touch_sample_pressure_trimmed_mean.sv */
// Resistive touch sampler. Each input beat is one poll (pen line level and raw
// X, Y, Z1, Z2 conversions); it yields at most one output beat. A poll that the
// pen line marks as up goes straight to the output register. A poll that needs
// the pressure passes two 32-bit multiply steps and the bit-per-cycle divider.
// A poll that completes a frame of FRAME_SAMPLES stored samples then walks the
// sample chain once for sum, minimum and maximum, and forms both trimmed means
// by multiplying with a reciprocal. Input is taken only between polls; a
// finished beat waits in the output register while the next poll is worked on.
module touch_sample_pressure_trimmed_mean
  import tspm_pkg::*;
#(
  parameter int unsigned FRAME_SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] pen_line_down, [12:1] raw_x, [24:13] raw_y, [36:25] raw_z1,
  // [48:37] raw_z2, [55:49] zero
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] touch_state, [1] touch_changed, [2] position_valid, [14:3] report_x,
  // [26:15] report_y, [38:27] pressure, [39] zero
  output logic [39:0] m_tdata,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(FRAME_SAMPLES);
  localparam int unsigned SUM_W = XY_W + $clog2(FRAME_SAMPLES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SAMPLES - 1);
  // Division by FRAME_SAMPLES - 2 is a multiply by the rounded-up reciprocal,
  // exact for every trimmed sum below 2^16.
  localparam int unsigned MEAN_SHIFT = 20;
  localparam int unsigned RECIP_W    = 21;
  localparam int unsigned MPROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((1 << MEAN_SHIFT) + FRAME_SAMPLES - 3) / (FRAME_SAMPLES - 2));

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_MUL1   = 8'b00000010,
    ST_MUL2   = 8'b00000100,
    ST_DIVP   = 8'b00001000,
    ST_DECIDE = 8'b00010000,
    ST_SCAN   = 8'b00100000,
    ST_MEAN   = 8'b01000000,
    ST_EMIT   = 8'b10000000
  } state_t;

  state_t state;

  logic [15:0]     plate_ohms;
  logic            line_present;
  logic [XY_W-1:0] press_limit;

  logic            pen_is_down;
  logic [IDX_W-1:0] stored_count;
  logic [IDX_W-1:0] scan_cnt;

  logic [XY_W-1:0]   smp_x;
  logic [XY_W-1:0]   smp_y;
  logic [XY_W-1:0]   smp_z1;
  logic [PROD_W-1:0] prod;
  logic [19:0]       rt;

  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [XY_W-1:0]  min_x;
  logic [XY_W-1:0]  max_x;
  logic [XY_W-1:0]  min_y;
  logic [XY_W-1:0]  max_y;

  logic            res_state;
  logic            res_changed;
  logic            res_valid;
  logic [XY_W-1:0] res_x;
  logic [XY_W-1:0] res_y;
  logic [XY_W-1:0] res_press;

  logic [XY_W-1:0] in_x;
  logic [XY_W-1:0] in_x_eff;
  logic [XY_W-1:0] in_z1;
  logic [XY_W-1:0] in_z2;
  logic            accept;

  logic [XY_W-1:0] cell_x [FRAME_SAMPLES];
  logic [XY_W-1:0] cell_y [FRAME_SAMPLES];
  logic            chain_shift;
  logic [XY_W-1:0] head_x;
  logic [XY_W-1:0] head_y;
  logic [XY_W-1:0] tail_x;
  logic [XY_W-1:0] tail_y;

  div_req_t          div_req;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [PROD_W-1:0] press_prod;
  logic [PROD_W-1:0] round_sum;
  logic [SUM_W-1:0]  trim_x;
  logic [SUM_W-1:0]  trim_y;
  logic [MPROD_W-1:0] mean_prod_x;
  logic [MPROD_W-1:0] mean_prod_y;
  logic              touch;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign in_x     = s_tdata[12:1];
  assign in_z1    = s_tdata[36:25];
  assign in_z2    = s_tdata[48:37];
  // A full-scale X reading means no contact and is taken as zero.
  assign in_x_eff = (in_x == FULL_SCALE) ? '0 : in_x;

  assign press_prod  = prod * PROD_W'(plate_ohms);
  assign round_sum   = div_quo + ROUND_ADD;
  assign trim_x      = sum_x - SUM_W'(min_x) - SUM_W'(max_x);
  assign trim_y      = sum_y - SUM_W'(min_y) - SUM_W'(max_y);
  assign mean_prod_x = MPROD_W'(trim_x) * MPROD_W'(MEAN_RECIP);
  assign mean_prod_y = MPROD_W'(trim_y) * MPROD_W'(MEAN_RECIP);
  assign touch       = (rt[11:0] < press_limit);

  // Sample chain: a new sample enters at the head; during the frame walk the
  // tail feeds back to the head so every sample passes the tail once.
  assign chain_shift = ((state == ST_DECIDE) && (rt[19:12] == '0) && touch) ||
                       (state == ST_SCAN);
  assign head_x = (state == ST_SCAN) ? tail_x : smp_x;
  assign head_y = (state == ST_SCAN) ? tail_y : smp_y;
  assign tail_x = cell_x[FRAME_SAMPLES-1];
  assign tail_y = cell_y[FRAME_SAMPLES-1];

  for (genvar i = 0; i < FRAME_SAMPLES; i++) begin : g_cell
    tspm_cell u_cell (
      .clk   (clk),
      .shift (chain_shift),
      .in_x  ((i == 0) ? head_x : cell_x[(i == 0) ? 0 : i-1]),
      .in_y  ((i == 0) ? head_y : cell_y[(i == 0) ? 0 : i-1]),
      .x     (cell_x[i]),
      .y     (cell_y[i])
    );
  end

  always_comb begin
    div_req.start = (state == ST_MUL2);
    div_req.steps = PRESS_STEPS;
  end

  tspm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (press_prod),
    .divisor  (smp_z1),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      plate_ohms   <= 16'd400;
      line_present <= 1'b1;
      press_limit  <= 12'd600;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PLATE_OHMS:   plate_ohms   <= cfg_data;
        REG_LINE_PRESENT: line_present <= cfg_data[0];
        REG_PRESS_LIMIT:  press_limit  <= cfg_data[XY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pen_is_down  <= 1'b0;
      stored_count <= '0;
      scan_cnt     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // In ST_EMIT the output register is reloaded rather than cleared.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (line_present && !s_tdata[0]) begin
              pen_is_down <= 1'b0;
              state       <= ST_EMIT;
            end else if (in_x_eff == '0 || in_z1 == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_MUL1;
            end
          end
        end
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_DIVP;
        ST_DIVP: begin
          if (div_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (rt[19:12] != '0) begin
            state <= ST_IDLE;
          end else if (touch) begin
            pen_is_down <= 1'b1;
            if (stored_count == LAST_IDX) begin
              stored_count <= '0;
              scan_cnt     <= LAST_IDX;
              state        <= ST_SCAN;
            end else begin
              stored_count <= stored_count + 1'b1;
              state        <= pen_is_down ? ST_IDLE : ST_EMIT;
            end
          end else if (!line_present && pen_is_down) begin
            pen_is_down <= 1'b0;
            state       <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt - 1'b1;
          if (scan_cnt == '0) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: state <= ST_EMIT;
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        smp_x  <= in_x_eff;
        smp_y  <= s_tdata[24:13];
        smp_z1 <= in_z1;
        prod   <= PROD_W'(in_z2) - PROD_W'(in_z1);
        rt     <= '0;
        // Up event from the pen line.
        res_state   <= 1'b0;
        res_changed <= 1'b1;
        res_valid   <= 1'b0;
        res_x       <= '0;
        res_y       <= '0;
        res_press   <= '0;
      end
      ST_MUL1: begin
        prod <= prod * PROD_W'(smp_x);
      end
      ST_DIVP: begin
        if (div_done) begin
          rt <= round_sum[PROD_W-1:12];
        end
      end
      ST_DECIDE: begin
        // Down event or frame result; an up event on pressure keeps the
        // zeroed fields loaded at accept.
        if (touch) begin
          res_state   <= 1'b1;
          res_changed <= !pen_is_down;
          res_press   <= rt[11:0];
        end
        sum_x <= '0;
        sum_y <= '0;
        min_x <= FULL_SCALE;
        min_y <= FULL_SCALE;
        max_x <= '0;
        max_y <= '0;
      end
      ST_SCAN: begin
        sum_x <= sum_x + SUM_W'(tail_x);
        sum_y <= sum_y + SUM_W'(tail_y);
        if (tail_x < min_x) begin
          min_x <= tail_x;
        end
        if (tail_x > max_x) begin
          max_x <= tail_x;
        end
        if (tail_y < min_y) begin
          min_y <= tail_y;
        end
        if (tail_y > max_y) begin
          max_y <= tail_y;
        end
      end
      ST_MEAN: begin
        // Axes are swapped on report.
        res_valid <= 1'b1;
        res_x     <= mean_prod_y[MEAN_SHIFT +: XY_W];
        res_y     <= mean_prod_x[MEAN_SHIFT +: XY_W];
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {1'b0, res_press, res_y, res_x, res_valid, res_changed, res_state};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
